// ===== rtl/led_blink_pattern_engine_macros.svh =====
// Assertion macros for the LED blink pattern engine.
// Used by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef LED_BLINK_PATTERN_ENGINE_MACROS_SVH
`define LED_BLINK_PATTERN_ENGINE_MACROS_SVH

// prop must hold at every edge outside reset
`define LBPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define LBPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lbpe_pkg.sv =====
// Shared types, codes and constants of the LED blink pattern engine.
// No dependencies; every other RTL file but the macro header uses it by scoped names.
package lbpe_pkg;

   localparam int unsigned FUNC_W     = 3;
   localparam int unsigned COLOR_W    = 2;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned CYC_W      = 16;
   localparam int unsigned RATE_W     = 21;
   localparam int unsigned TICKS_W    = 27;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 21;

   // tick rate split as rate = quot * 1000 + rem
   localparam int unsigned MS_PER_SEC = 1000;
   localparam int unsigned QUOT_W     = 12;
   localparam int unsigned REM_W      = 10;
   localparam int unsigned QUOT_RCP_W = 22;
   localparam int unsigned QUOT_SHIFT = 31;
   localparam logic [QUOT_RCP_W-1:0] QUOT_RCP = 22'd2147484;

   // ms * quot, and floor(ms * rem / 1000) by reciprocal
   localparam int unsigned WHOLE_W    = 28;
   localparam int unsigned PART_W     = 26;
   localparam int unsigned FRAC_RCP_W = 27;
   localparam int unsigned FRAC_SHIFT = 36;
   localparam int unsigned FRAC_W     = 16;
   localparam logic [FRAC_RCP_W-1:0] FRAC_RCP = 27'd68719477;

   localparam logic [RATE_W-1:0]  RATE_RESET   = 21'd32768;
   localparam logic [QUOT_W-1:0]  QUOT_RESET   = 12'd32;
   localparam logic [REM_W-1:0]   REM_RESET    = 10'd768;
   localparam logic [1:0]         RATE_SETTLE  = 2'd2;
   localparam logic [TICKS_W-1:0] TICKS_ONE    = 27'd1;
   localparam logic [CYC_W-1:0]   CYC_ONE      = 16'd1;
   localparam int unsigned        RED_BIT      = 0;
   localparam int unsigned        GREEN_BIT    = 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK      = 3'd0,
      FUNC_START     = 3'd1,
      FUNC_CANCEL    = 3'd2,
      FUNC_LAMPS_ON  = 3'd3,
      FUNC_LAMPS_OFF = 3'd4,
      FUNC_TOGGLE    = 3'd5
   } lbpe_func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TICK_RATE   = 1'b0,
      REG_LAMPS_READY = 1'b1
   } lbpe_reg_type;

   typedef struct packed {
      logic                refresh;
      logic [FUNC_W-1:0]   func;
      logic [COLOR_W-1:0]  color;
      logic [COLOR_W-1:0]  off_color;
      logic [COLOR_W-1:0]  final_color;
      logic [MS_W-1:0]     on_ms;
      logic [MS_W-1:0]     off_ms;
      logic [CYC_W-1:0]    count;
      logic                only_when_idle;
   } lbpe_cmd_type;

   typedef struct packed {
      logic               busy;
      logic [QUOT_W-1:0]  quot;
      logic [REM_W-1:0]   rem;
   } lbpe_rate_type;

   typedef struct packed {
      logic [TICKS_W-1:0] on_len;
      logic [TICKS_W-1:0] off_len;
   } lbpe_len_type;

   typedef struct packed {
      logic [MS_W-1:0] on_ms;
      logic [MS_W-1:0] off_ms;
   } lbpe_hold_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } lbpe_stage_en_type;

endpackage

// ===== rtl/lbpe_if.sv =====
// Request and response channel interfaces of the LED blink pattern engine.
// Depends on lbpe_pkg for field widths.
interface lbpe_req_if;
   logic                             valid;
   logic                             ready;
   logic [lbpe_pkg::FUNC_W-1:0]      func;
   logic [lbpe_pkg::COLOR_W-1:0]     color;
   logic [lbpe_pkg::COLOR_W-1:0]     off_color;
   logic [lbpe_pkg::COLOR_W-1:0]     final_color;
   logic [lbpe_pkg::MS_W-1:0]        on_time_ms;
   logic [lbpe_pkg::MS_W-1:0]        off_time_ms;
   logic [lbpe_pkg::CYC_W-1:0]       cycle_count;
   logic                             only_when_idle;

   modport source (output valid, func, color, off_color, final_color, on_time_ms,
                   off_time_ms, cycle_count, only_when_idle, input ready);
   modport sink   (input valid, func, color, off_color, final_color, on_time_ms,
                   off_time_ms, cycle_count, only_when_idle, output ready);
endinterface

interface lbpe_rsp_if;
   logic valid;
   logic ready;
   logic red_lit;
   logic green_lit;
   logic pattern_busy;

   modport source (output valid, red_lit, green_lit, pattern_busy, input ready);
   modport sink   (input valid, red_lit, green_lit, pattern_busy, output ready);
endinterface

// ===== rtl/lbpe_rate_div.sv =====
// Configuration registers; splits the tick rate into rate / 1000 and rate % 1000.
// Depends on lbpe_pkg.
module lbpe_rate_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lbpe_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [lbpe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lbpe_pkg::lbpe_rate_type             rate,
   output logic                                lamps_ready
);

   logic [lbpe_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [lbpe_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [lbpe_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [1:0]                   settle_ff, settle_in;
   logic                         ready_ff, ready_in;
   logic [lbpe_pkg::RATE_W+lbpe_pkg::QUOT_RCP_W-1:0] quot_prod;
   logic [lbpe_pkg::RATE_W-1:0]  rem_full;
   logic                         wr_rate;

   assign wr_rate = csr_we && (csr_idx == lbpe_pkg::REG_TICK_RATE);

   assign quot_prod = (lbpe_pkg::RATE_W + lbpe_pkg::QUOT_RCP_W)'(rate_ff)
                    * (lbpe_pkg::RATE_W + lbpe_pkg::QUOT_RCP_W)'(lbpe_pkg::QUOT_RCP);
   assign quot_in   = quot_prod[lbpe_pkg::QUOT_SHIFT +: lbpe_pkg::QUOT_W];
   assign rem_full  = rate_ff - lbpe_pkg::RATE_W'(quot_ff)
                    * lbpe_pkg::RATE_W'(lbpe_pkg::MS_PER_SEC);
   assign rem_in    = rem_full[lbpe_pkg::REM_W-1:0];

   always_comb begin
      rate_in   = rate_ff;
      ready_in  = ready_ff;
      settle_in = settle_ff;
      if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
      if (wr_rate) begin
         rate_in   = csr_wdata[lbpe_pkg::RATE_W-1:0];
         settle_in = lbpe_pkg::RATE_SETTLE;
      end
      if (csr_we && (csr_idx == lbpe_pkg::REG_LAMPS_READY)) begin
         ready_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= lbpe_pkg::RATE_RESET;
         quot_ff   <= lbpe_pkg::QUOT_RESET;
         rem_ff    <= lbpe_pkg::REM_RESET;
         settle_ff <= 2'd0;
         ready_ff  <= 1'b0;
      end else begin
         rate_ff   <= rate_in;
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         settle_ff <= settle_in;
         ready_ff  <= ready_in;
      end
   end

   assign rate.busy   = (settle_ff != 2'd0);
   assign rate.quot   = quot_ff;
   assign rate.rem    = rem_ff;
   assign lamps_ready = ready_ff;

endmodule

// ===== rtl/lbpe_phase_len.sv =====
// Three-stage pipeline turning on/off times in ms into phase lengths in ticks.
// Depends on lbpe_pkg; carries the command word alongside.
module lbpe_phase_len (
   input  logic                        clock,
   input  lbpe_pkg::lbpe_stage_en_type en,
   input  lbpe_pkg::lbpe_rate_type     rate,
   input  lbpe_pkg::lbpe_cmd_type      s0_cmd,
   output lbpe_pkg::lbpe_cmd_type      s3_cmd,
   output lbpe_pkg::lbpe_len_type      s3_len
);

   localparam int unsigned FracProdW = lbpe_pkg::PART_W + lbpe_pkg::FRAC_RCP_W;

   lbpe_pkg::lbpe_cmd_type s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic [lbpe_pkg::WHOLE_W-1:0] s1_whole_on_ff, s1_whole_off_ff;
   logic [lbpe_pkg::PART_W-1:0]  s1_part_on_ff, s1_part_off_ff;
   logic [lbpe_pkg::WHOLE_W-1:0] s2_whole_on_ff, s2_whole_off_ff;
   logic [lbpe_pkg::FRAC_W-1:0]  s2_frac_on_ff, s2_frac_off_ff;
   logic [lbpe_pkg::TICKS_W-1:0] s3_on_ff, s3_off_ff;

   logic [lbpe_pkg::WHOLE_W-1:0] whole_on_in, whole_off_in;
   logic [lbpe_pkg::PART_W-1:0]  part_on_in, part_off_in;
   logic [FracProdW-1:0]         frac_prod_on, frac_prod_off;
   logic [lbpe_pkg::TICKS_W-1:0] on_len_in, off_len_in;

   function automatic logic [lbpe_pkg::TICKS_W-1:0] clamp_len(
      input logic [lbpe_pkg::WHOLE_W-1:0] whole,
      input logic [lbpe_pkg::FRAC_W-1:0]  frac
   );
      logic [lbpe_pkg::WHOLE_W-1:0] sum;
      logic [lbpe_pkg::TICKS_W-1:0] t;
      sum = whole + lbpe_pkg::WHOLE_W'(frac);
      t   = sum[lbpe_pkg::TICKS_W-1:0];
      return (t == '0) ? lbpe_pkg::TICKS_ONE : t;
   endfunction

   // stage 1: ms * (rate / 1000) and ms * (rate % 1000)
   assign whole_on_in  = lbpe_pkg::WHOLE_W'(s0_cmd.on_ms)  * lbpe_pkg::WHOLE_W'(rate.quot);
   assign whole_off_in = lbpe_pkg::WHOLE_W'(s0_cmd.off_ms) * lbpe_pkg::WHOLE_W'(rate.quot);
   assign part_on_in   = lbpe_pkg::PART_W'(s0_cmd.on_ms)   * lbpe_pkg::PART_W'(rate.rem);
   assign part_off_in  = lbpe_pkg::PART_W'(s0_cmd.off_ms)  * lbpe_pkg::PART_W'(rate.rem);

   // stage 2: remainder part / 1000 by reciprocal, exact for 26-bit values
   assign frac_prod_on  = FracProdW'(s1_part_on_ff)  * FracProdW'(lbpe_pkg::FRAC_RCP);
   assign frac_prod_off = FracProdW'(s1_part_off_ff) * FracProdW'(lbpe_pkg::FRAC_RCP);

   // stage 3: sum, wrap to counter width, at least one tick
   assign on_len_in  = clamp_len(s2_whole_on_ff,  s2_frac_on_ff);
   assign off_len_in = clamp_len(s2_whole_off_ff, s2_frac_off_ff);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_cmd_ff       <= s0_cmd;
         s1_whole_on_ff  <= whole_on_in;
         s1_whole_off_ff <= whole_off_in;
         s1_part_on_ff   <= part_on_in;
         s1_part_off_ff  <= part_off_in;
      end
      if (en.s2) begin
         s2_cmd_ff       <= s1_cmd_ff;
         s2_whole_on_ff  <= s1_whole_on_ff;
         s2_whole_off_ff <= s1_whole_off_ff;
         s2_frac_on_ff   <= frac_prod_on[lbpe_pkg::FRAC_SHIFT +: lbpe_pkg::FRAC_W];
         s2_frac_off_ff  <= frac_prod_off[lbpe_pkg::FRAC_SHIFT +: lbpe_pkg::FRAC_W];
      end
      if (en.s3) begin
         s3_cmd_ff <= s2_cmd_ff;
         s3_on_ff  <= on_len_in;
         s3_off_ff <= off_len_in;
      end
   end

   assign s3_cmd         = s3_cmd_ff;
   assign s3_len.on_len  = s3_on_ff;
   assign s3_len.off_len = s3_off_ff;

endmodule

// ===== rtl/lbpe_state.sv =====
// Pattern state and lamp mask update; the state registers are the response word.
// Depends on lbpe_pkg, lbpe_if and the assertion macro header.
`include "led_blink_pattern_engine_macros.svh"

module lbpe_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    refresh_wr,
   input  lbpe_pkg::lbpe_cmd_type  cmd,
   input  lbpe_pkg::lbpe_len_type  len,
   input  logic                    lamps_ready,
   output lbpe_pkg::lbpe_hold_type hold,
   lbpe_rsp_if.source              rsp
);

   logic [lbpe_pkg::COLOR_W-1:0] lamp_mask_ff, lamp_mask_in;
   logic                         running_ff, running_in;
   logic                         in_on_half_ff, in_on_half_in;
   logic [lbpe_pkg::CYC_W-1:0]   cycles_left_ff, cycles_left_in;
   logic [lbpe_pkg::TICKS_W-1:0] ticks_left_ff, ticks_left_in;
   logic [lbpe_pkg::COLOR_W-1:0] on_color_ff, on_color_in;
   logic [lbpe_pkg::COLOR_W-1:0] off_color_ff, off_color_in;
   logic [lbpe_pkg::COLOR_W-1:0] final_color_ff, final_color_in;
   logic [lbpe_pkg::MS_W-1:0]    on_ms_ff, on_ms_in;
   logic [lbpe_pkg::MS_W-1:0]    off_ms_ff, off_ms_in;
   logic [lbpe_pkg::TICKS_W-1:0] on_len_ff, on_len_in;
   logic [lbpe_pkg::TICKS_W-1:0] off_len_ff, off_len_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         take;
   logic                         direct_ok;

   assign in_ready  = !rsp_valid_ff || rsp.ready;
   assign take      = in_valid && in_ready;
   assign direct_ok = lamps_ready && !(cmd.only_when_idle && running_ff);

   always_comb begin
      lamp_mask_in   = lamp_mask_ff;
      running_in     = running_ff;
      in_on_half_in  = in_on_half_ff;
      cycles_left_in = cycles_left_ff;
      ticks_left_in  = ticks_left_ff;
      on_color_in    = on_color_ff;
      off_color_in   = off_color_ff;
      final_color_in = final_color_ff;
      on_ms_in       = on_ms_ff;
      off_ms_in      = off_ms_ff;
      on_len_in      = on_len_ff;
      off_len_in     = off_len_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;

      if (refresh_wr) begin
         on_len_in  = len.on_len;
         off_len_in = len.off_len;
      end

      if (take) begin
         rsp_valid_in = 1'b1;
         case (cmd.func)
            lbpe_pkg::FUNC_TICK: begin
               if (running_ff) begin
                  if (ticks_left_ff > lbpe_pkg::TICKS_ONE) begin
                     ticks_left_in = ticks_left_ff - lbpe_pkg::TICKS_ONE;
                  end else if (in_on_half_ff) begin
                     in_on_half_in = 1'b0;
                     lamp_mask_in  = off_color_ff;
                     ticks_left_in = off_len_ff;
                  end else begin
                     cycles_left_in = cycles_left_ff - lbpe_pkg::CYC_ONE;
                     if (cycles_left_ff != lbpe_pkg::CYC_ONE) begin
                        in_on_half_in = 1'b1;
                        lamp_mask_in  = on_color_ff;
                        ticks_left_in = on_len_ff;
                     end else begin
                        lamp_mask_in  = final_color_ff;
                        running_in    = 1'b0;
                        ticks_left_in = '0;
                     end
                  end
               end
            end
            lbpe_pkg::FUNC_START: begin
               if (lamps_ready && (cmd.count != '0)) begin
                  on_color_in    = cmd.color;
                  off_color_in   = cmd.off_color;
                  final_color_in = cmd.final_color;
                  on_ms_in       = cmd.on_ms;
                  off_ms_in      = cmd.off_ms;
                  on_len_in      = len.on_len;
                  off_len_in     = len.off_len;
                  cycles_left_in = cmd.count;
                  in_on_half_in  = 1'b1;
                  running_in     = 1'b1;
                  lamp_mask_in   = cmd.color;
                  ticks_left_in  = len.on_len;
               end
            end
            lbpe_pkg::FUNC_CANCEL: begin
               if (lamps_ready) begin
                  running_in   = 1'b0;
                  lamp_mask_in = '0;
               end
            end
            lbpe_pkg::FUNC_LAMPS_ON: begin
               if (direct_ok) begin
                  lamp_mask_in = lamp_mask_ff | cmd.color;
               end
            end
            lbpe_pkg::FUNC_LAMPS_OFF: begin
               if (direct_ok) begin
                  lamp_mask_in = lamp_mask_ff & ~cmd.color;
               end
            end
            lbpe_pkg::FUNC_TOGGLE: begin
               if (direct_ok) begin
                  lamp_mask_in = lamp_mask_ff ^ cmd.color;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_mask_ff   <= '0;
         running_ff     <= 1'b0;
         in_on_half_ff  <= 1'b0;
         cycles_left_ff <= '0;
         ticks_left_ff  <= '0;
         on_color_ff    <= '0;
         off_color_ff   <= '0;
         final_color_ff <= '0;
         on_ms_ff       <= '0;
         off_ms_ff      <= '0;
         on_len_ff      <= lbpe_pkg::TICKS_ONE;
         off_len_ff     <= lbpe_pkg::TICKS_ONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lamp_mask_ff   <= lamp_mask_in;
         running_ff     <= running_in;
         in_on_half_ff  <= in_on_half_in;
         cycles_left_ff <= cycles_left_in;
         ticks_left_ff  <= ticks_left_in;
         on_color_ff    <= on_color_in;
         off_color_ff   <= off_color_in;
         final_color_ff <= final_color_in;
         on_ms_ff       <= on_ms_in;
         off_ms_ff      <= off_ms_in;
         on_len_ff      <= on_len_in;
         off_len_ff     <= off_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.red_lit      = lamp_mask_ff[lbpe_pkg::RED_BIT];
   assign rsp.green_lit    = lamp_mask_ff[lbpe_pkg::GREEN_BIT];
   assign rsp.pattern_busy = running_ff;
   assign hold.on_ms       = on_ms_ff;
   assign hold.off_ms      = off_ms_ff;

   `LBPE_ASSERT(a_run_has_ticks, clock, reset, !running_ff || (ticks_left_ff != '0), "running with zero ticks")
   `LBPE_ASSERT(a_run_has_cycles, clock, reset, !running_ff || (cycles_left_ff != '0), "running with zero cycles")
   `LBPE_ASSERT_NEXT(a_idle_tick_quiet, clock, reset, take && (cmd.func == lbpe_pkg::FUNC_TICK) && !running_ff, lamp_mask_ff == $past(lamp_mask_ff), "idle tick moved lamps")

endmodule

// ===== rtl/led_blink_pattern_engine.sv =====
// channel  | dir | handshake   | word
// req_chan | in  | valid/ready | func, colours, on/off ms, cycle count, idle-only flag
// rsp_chan | out | valid/ready | red_lit, green_lit, pattern_busy
// csr_*    | in  | write only  | index 0 tick rate, index 1 lamps ready
// One word per cycle unless a response stall or CSR write drops req_chan.ready.
// Words pass input register, two multiply stages, length sum, state/response register.
// A tick-rate write holds req_chan.ready low while the rate split settles and until
// a refresh word carrying the held on/off times is injected into the length pipeline.
// Stages only advance into empty or moving slots, so a stalled response fills the
// pipeline before req_chan.ready drops. Reset is synchronous, active high.
`include "led_blink_pattern_engine_macros.svh"

module led_blink_pattern_engine (
   input  logic                            clock,
   input  logic                            reset,
   lbpe_req_if.sink                        req_chan,
   lbpe_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [lbpe_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [lbpe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lbpe_pkg::lbpe_rate_type     rate_st;
   lbpe_pkg::lbpe_cmd_type      s0_cmd_ff, s0_cmd_in, s3_cmd;
   lbpe_pkg::lbpe_len_type      s3_len;
   lbpe_pkg::lbpe_hold_type     hold;
   lbpe_pkg::lbpe_stage_en_type stage_en;
   logic lamps_ready;
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic refresh_pend_ff, refresh_pend_in;
   logic state_ready;
   logic s0_move, s1_move, s2_move, s3_move;
   logic s0_free, s1_free, s2_free, s3_free;
   logic inject, accept, wr_rate;

   lbpe_rate_div u_rate (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata),
      .rate        (rate_st),
      .lamps_ready (lamps_ready)
   );

   // stage handshake, bubbles collapse
   assign s3_move = s3_valid_ff && (s3_cmd.refresh || state_ready);
   assign s3_free = !s3_valid_ff || s3_move;
   assign s2_move = s2_valid_ff && s3_free;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_move = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s0_move = s0_valid_ff && s1_free;
   assign s0_free = !s0_valid_ff || s1_free;

   assign wr_rate        = csr_we && (csr_idx == lbpe_pkg::REG_TICK_RATE);
   assign inject         = refresh_pend_ff && !rate_st.busy && s0_free && !csr_we;
   assign req_chan.ready = s0_free && !refresh_pend_ff && !csr_we;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s0_cmd_in = s0_cmd_ff;
      if (inject) begin
         s0_cmd_in        = '0;
         s0_cmd_in.refresh = 1'b1;
         s0_cmd_in.on_ms  = hold.on_ms;
         s0_cmd_in.off_ms = hold.off_ms;
      end else if (accept) begin
         s0_cmd_in.refresh        = 1'b0;
         s0_cmd_in.func           = req_chan.func;
         s0_cmd_in.color          = req_chan.color;
         s0_cmd_in.off_color      = req_chan.off_color;
         s0_cmd_in.final_color    = req_chan.final_color;
         s0_cmd_in.on_ms          = req_chan.on_time_ms;
         s0_cmd_in.off_ms         = req_chan.off_time_ms;
         s0_cmd_in.count          = req_chan.cycle_count;
         s0_cmd_in.only_when_idle = req_chan.only_when_idle;
      end
   end

   assign s0_valid_in     = inject || accept || (s0_valid_ff && !s0_move);
   assign s1_valid_in     = s0_move || (s1_valid_ff && !s1_move);
   assign s2_valid_in     = s1_move || (s2_valid_ff && !s2_move);
   assign s3_valid_in     = s2_move || (s3_valid_ff && !s3_move);
   assign refresh_pend_in = wr_rate || (refresh_pend_ff && !inject);

   always_ff @(posedge clock) begin
      s0_cmd_ff <= s0_cmd_in;
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         refresh_pend_ff <= 1'b0;
      end else begin
         s0_valid_ff     <= s0_valid_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         refresh_pend_ff <= refresh_pend_in;
      end
   end

   assign stage_en.s1 = s0_move;
   assign stage_en.s2 = s1_move;
   assign stage_en.s3 = s2_move;

   lbpe_phase_len u_len (
      .clock  (clock),
      .en     (stage_en),
      .rate   (rate_st),
      .s0_cmd (s0_cmd_ff),
      .s3_cmd (s3_cmd),
      .s3_len (s3_len)
   );

   lbpe_state u_state (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid_ff && !s3_cmd.refresh),
      .in_ready    (state_ready),
      .refresh_wr  (s3_valid_ff && s3_cmd.refresh),
      .cmd         (s3_cmd),
      .len         (s3_len),
      .lamps_ready (lamps_ready),
      .hold        (hold),
      .rsp         (rsp_chan)
   );

   `LBPE_ASSERT_NEXT(a_inject_loads, clock, reset, inject, s0_valid_ff && s0_cmd_ff.refresh, "refresh word not loaded")
   `LBPE_ASSERT_NEXT(a_rate_wr_blocks, clock, reset, wr_rate, !req_chan.ready, "request taken after rate write")
   `LBPE_ASSERT(a_settle_pending, clock, reset, !rate_st.busy || refresh_pend_ff, "rate settling without refresh")

endmodule

// ===== tb/sv/tb_led_blink_pattern_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_blink_pattern_engine: directed table, then random phases.
// Predicts lamp and busy state per request word; needs lbpe_pkg, lbpe_if and the RTL.
module tb_led_blink_pattern_engine;
   import lbpe_pkg::*;

   localparam int unsigned RESET_CYCLES = 4;
   localparam int unsigned IDLE_GAP     = 8;
   localparam int unsigned TAIL_CYCLES  = 16;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_WORDS  = 250;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COLOR_W-1:0] color;
      logic [COLOR_W-1:0] off_color;
      logic [COLOR_W-1:0] final_color;
      logic [MS_W-1:0]    on_ms;
      logic [MS_W-1:0]    off_ms;
      logic [CYC_W-1:0]   count;
      logic               idle_only;
   } cmd_word_t;

   typedef struct packed {
      logic red;
      logic green;
      logic busy;
   } lamp_state_t;

   typedef struct packed {
      bit                     is_csr;
      lbpe_reg_type           csr_sel;
      logic [CSR_DATA_W-1:0]  csr_val;
      cmd_word_t              cmd;
      bit                     typed;
      lamp_state_t            want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lbpe_req_if req_chan_if ();
   lbpe_rsp_if rsp_chan_if ();

   led_blink_pattern_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan_if),
      .rsp_chan  (rsp_chan_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // engine model state
   logic [RATE_W-1:0]  eng_rate;
   logic               eng_ready;
   logic [COLOR_W-1:0] eng_mask;
   logic               eng_running;
   logic               eng_in_on;
   logic [CYC_W-1:0]   eng_cycles;
   logic [TICKS_W-1:0] eng_ticks;
   logic [COLOR_W-1:0] eng_on_col;
   logic [COLOR_W-1:0] eng_off_col;
   logic [COLOR_W-1:0] eng_fin_col;
   logic [MS_W-1:0]    eng_on_ms;
   logic [MS_W-1:0]    eng_off_ms;

   lamp_state_t lamp_expect_q[$];
   int unsigned mismatches = 0;
   int unsigned rsp_words  = 0;
   bit          fast_mode  = 1'b0;
   bit          hold_rsp   = 1'b0;
   bit          req_offered = 1'b0;
   dir_row_t    dir_rows[$];

   function automatic logic [TICKS_W-1:0] phase_len(input logic [MS_W-1:0] ms);
      logic [63:0] prod;
      prod = (64'(ms) * 64'(eng_rate)) / 64'(MS_PER_SEC);
      if (prod[TICKS_W-1:0] == '0) return TICKS_ONE;
      return prod[TICKS_W-1:0];
   endfunction

   function automatic lamp_state_t step_lamp_model(input cmd_word_t w);
      lamp_state_t s;
      bit gated;
      gated = w.idle_only && eng_running;
      if (w.func == FUNC_TICK) begin
         if (eng_running) begin
            if (eng_ticks > TICKS_ONE) begin
               eng_ticks = eng_ticks - TICKS_ONE;
            end else if (eng_in_on) begin
               eng_in_on = 1'b0;
               eng_mask  = eng_off_col;
               eng_ticks = phase_len(eng_off_ms);
            end else begin
               eng_cycles = eng_cycles - CYC_ONE;
               if (eng_cycles != '0) begin
                  eng_in_on = 1'b1;
                  eng_mask  = eng_on_col;
                  eng_ticks = phase_len(eng_on_ms);
               end else begin
                  eng_mask    = eng_fin_col;
                  eng_running = 1'b0;
                  eng_ticks   = '0;
               end
            end
         end
      end else if (eng_ready) begin
         case (w.func)
            FUNC_START: begin
               if (w.count != '0) begin
                  eng_on_col  = w.color;
                  eng_off_col = w.off_color;
                  eng_fin_col = w.final_color;
                  eng_on_ms   = w.on_ms;
                  eng_off_ms  = w.off_ms;
                  eng_cycles  = w.count;
                  eng_in_on   = 1'b1;
                  eng_running = 1'b1;
                  eng_mask    = w.color;
                  eng_ticks   = phase_len(w.on_ms);
               end
            end
            FUNC_CANCEL: begin
               eng_running = 1'b0;
               eng_mask    = '0;
            end
            FUNC_LAMPS_ON:  if (!gated) eng_mask = eng_mask | w.color;
            FUNC_LAMPS_OFF: if (!gated) eng_mask = eng_mask & ~w.color;
            FUNC_TOGGLE:    if (!gated) eng_mask = eng_mask ^ w.color;
            default: ;
         endcase
      end
      s.red   = eng_mask[RED_BIT];
      s.green = eng_mask[GREEN_BIT];
      s.busy  = eng_running;
      return s;
   endfunction

   function automatic cmd_word_t mk_cmd(input logic [FUNC_W-1:0] f,
                                        input logic [COLOR_W-1:0] c, oc, fc,
                                        input logic [MS_W-1:0] on_ms, off_ms,
                                        input logic [CYC_W-1:0] cnt, input logic idle);
      cmd_word_t w;
      w.func = f; w.color = c; w.off_color = oc; w.final_color = fc;
      w.on_ms = on_ms; w.off_ms = off_ms; w.count = cnt; w.idle_only = idle;
      return w;
   endfunction

   function automatic dir_row_t known_row(input cmd_word_t c, input logic r, g, b);
      dir_row_t row;
      row = '0;
      row.cmd = c; row.typed = 1'b1;
      row.want.red = r; row.want.green = g; row.want.busy = b;
      return row;
   endfunction

   function automatic dir_row_t pred_row(input cmd_word_t c);
      dir_row_t row;
      row = '0;
      row.cmd = c;
      return row;
   endfunction

   function automatic dir_row_t csr_row(input lbpe_reg_type sel, input logic [CSR_DATA_W-1:0] v);
      dir_row_t row;
      row = '0;
      row.is_csr = 1'b1; row.csr_sel = sel; row.csr_val = v;
      return row;
   endfunction

   // phase times kept short for the current rate, with the odd full-range value
   function automatic logic [MS_W-1:0] pick_ms();
      int unsigned cap;
      if ($urandom_range(0, 9) == 0) return MS_W'($urandom);
      cap = 8000 / eng_rate;
      if (cap > 65535) cap = 65535;
      return MS_W'($urandom_range(0, cap));
   endfunction

   function automatic cmd_word_t rand_cmd();
      cmd_word_t w;
      int unsigned r;
      int unsigned k;
      w.color       = COLOR_W'($urandom);
      w.off_color   = COLOR_W'($urandom);
      w.final_color = COLOR_W'($urandom);
      w.on_ms       = pick_ms();
      w.off_ms      = pick_ms();
      w.idle_only   = 1'($urandom);
      k = $urandom_range(0, 99);
      if (k < 5)       w.count = '0;
      else if (k < 45) w.count = CYC_ONE;
      else if (k < 80) w.count = CYC_W'($urandom_range(2, 4));
      else if (k < 95) w.count = CYC_W'($urandom);
      else             w.count = '1;
      r = $urandom_range(0, 99);
      if (r < 50)      w.func = FUNC_TICK;
      else if (r < 65) w.func = FUNC_START;
      else if (r < 70) w.func = FUNC_CANCEL;
      else if (r < 78) w.func = FUNC_LAMPS_ON;
      else if (r < 86) w.func = FUNC_LAMPS_OFF;
      else if (r < 96) w.func = FUNC_TOGGLE;
      else if (r < 98) w.func = FUNC_SPARE_A;
      else             w.func = FUNC_SPARE_B;
      return w;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic send_word(input cmd_word_t w);
      int unsigned gap;
      gap = fast_mode ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_chan_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan_if.valid          <= 1'b1;
      req_chan_if.func           <= w.func;
      req_chan_if.color          <= w.color;
      req_chan_if.off_color      <= w.off_color;
      req_chan_if.final_color    <= w.final_color;
      req_chan_if.on_time_ms     <= w.on_ms;
      req_chan_if.off_time_ms    <= w.off_ms;
      req_chan_if.cycle_count    <= w.count;
      req_chan_if.only_when_idle <= w.idle_only;
      do @(posedge clock); while (!req_chan_if.ready);
      req_offered = 1'b1;
   endtask

   task automatic release_req();
      if (req_offered) begin
         req_chan_if.valid <= 1'b0;
         req_offered = 1'b0;
      end
   endtask

   task automatic wait_drained();
      while (lamp_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input lbpe_reg_type sel, input logic [CSR_DATA_W-1:0] v);
      wait_drained();
      repeat (IDLE_GAP) @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= sel;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == REG_TICK_RATE) eng_rate = v[RATE_W-1:0];
      else                      eng_ready = v[0];
   endtask

   // response side
   initial begin : rsp_side
      int unsigned gap;
      lamp_state_t w;
      rsp_chan_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = fast_mode ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_chan_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan_if.valid);
         rsp_words++;
         if (lamp_expect_q.size() == 0) begin
            note_mismatch($sformatf("word %0d arrived with nothing expected", rsp_words));
         end else begin
            w = lamp_expect_q.pop_front();
            if (rsp_chan_if.red_lit !== w.red)
               note_mismatch($sformatf("word %0d red_lit %b want %b",
                                       rsp_words, rsp_chan_if.red_lit, w.red));
            if (rsp_chan_if.green_lit !== w.green)
               note_mismatch($sformatf("word %0d green_lit %b want %b",
                                       rsp_words, rsp_chan_if.green_lit, w.green));
            if (rsp_chan_if.pattern_busy !== w.busy)
               note_mismatch($sformatf("word %0d pattern_busy %b want %b",
                                       rsp_words, rsp_chan_if.pattern_busy, w.busy));
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan_if.valid && req_chan_if.ready) ||
             (rsp_chan_if.valid && rsp_chan_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL led_blink_pattern_engine");
      $finish;
   end

   initial begin : req_side
      int unsigned phase_rate[PHASES];
      bit          phase_ready[PHASES];
      cmd_word_t   c;
      lamp_state_t s;

      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_idx   = REG_TICK_RATE;
      csr_wdata = '0;
      req_chan_if.valid          = 1'b0;
      req_chan_if.func           = FUNC_TICK;
      req_chan_if.color          = '0;
      req_chan_if.off_color      = '0;
      req_chan_if.final_color    = '0;
      req_chan_if.on_time_ms     = '0;
      req_chan_if.off_time_ms    = '0;
      req_chan_if.cycle_count    = '0;
      req_chan_if.only_when_idle = 1'b0;

      eng_rate = RATE_RESET; eng_ready = 1'b0; eng_mask = '0; eng_running = 1'b0;
      eng_in_on = 1'b0; eng_cycles = '0; eng_ticks = '0; eng_on_col = '0;
      eng_off_col = '0; eng_fin_col = '0; eng_on_ms = '0; eng_off_ms = '0;

      // lamps not ready: only ticks act
      dir_rows.push_back(known_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                                   1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_START, 2'd3, 2'd3, 2'd3, 16'd5, 16'd5, 16'd5, 1'b0),
                                   1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_LAMPS_ON, 2'd3, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                          1'b0), 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_CANCEL, 2'd3, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                          1'b1), 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(csr_row(REG_LAMPS_READY, 21'd1));
      dir_rows.push_back(csr_row(REG_TICK_RATE, 21'd1000));
      // direct commands
      dir_rows.push_back(known_row(mk_cmd(FUNC_LAMPS_ON, 2'd1, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                          1'b0), 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_TOGGLE, 2'd3, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                                   1'b0, 1'b1, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_LAMPS_OFF, 2'd2, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                          1'b1), 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_SPARE_A, 2'd3, 2'd3, 2'd3, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 1'b1), 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_SPARE_B, 2'd3, 2'd3, 2'd3, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 1'b0), 1'b0, 1'b0, 1'b0));
      // two short cycles run to completion, idle-only gating on the way
      dir_rows.push_back(known_row(mk_cmd(FUNC_START, 2'd1, 2'd2, 2'd3, 16'd2, 16'd1, 16'd2, 1'b0),
                                   1'b1, 1'b0, 1'b1));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_LAMPS_ON, 2'd2, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                         1'b1)));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_TOGGLE, 2'd1, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0)));
      repeat (6)
         dir_rows.push_back(pred_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0,
                                            1'b0)));
      // zero-length phase, maximum count, then a start over a running pattern
      dir_rows.push_back(known_row(mk_cmd(FUNC_START, 2'd3, 2'd0, 2'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                                          1'b1), 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0)));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_START, 2'd2, 2'd1, 2'd0, 16'd1, 16'd0, 16'd1, 1'b0)));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0)));
      dir_rows.push_back(known_row(mk_cmd(FUNC_CANCEL, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                                   1'b0, 1'b0, 1'b0));
      dir_rows.push_back(known_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                                   1'b0, 1'b0, 1'b0));
      // rate extremes
      dir_rows.push_back(csr_row(REG_TICK_RATE, 21'd1));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_START, 2'd3, 2'd1, 2'd2, 16'hFFFF, 16'd0, 16'd1,
                                         1'b0)));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0)));
      dir_rows.push_back(csr_row(REG_TICK_RATE, 21'd1048576));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_START, 2'd1, 2'd3, 2'd0, 16'hFFFF, 16'hFFFF, 16'd3,
                                         1'b1)));
      dir_rows.push_back(pred_row(mk_cmd(FUNC_TICK, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0)));
      dir_rows.push_back(known_row(mk_cmd(FUNC_CANCEL, 2'd0, 2'd0, 2'd0, 16'd0, 16'd0, 16'd0, 1'b1),
                                   1'b0, 1'b0, 1'b0));

      phase_rate[0] = 1000;    phase_ready[0] = 1'b1;
      phase_rate[1] = 1;       phase_ready[1] = 1'b1;
      phase_rate[2] = 1048576; phase_ready[2] = 1'b1;
      phase_rate[3] = 32768;   phase_ready[3] = 1'b0;
      phase_rate[4] = $urandom_range(1, 4000);    phase_ready[4] = 1'b1;
      phase_rate[5] = $urandom_range(1, 1048576); phase_ready[5] = 1'b1;
      phase_rate[6] = 250;     phase_ready[6] = 1'b1;
      phase_rate[7] = $urandom_range(1, 2000);    phase_ready[7] = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            release_req();
            write_csr(dir_rows[i].csr_sel, dir_rows[i].csr_val);
         end else begin
            send_word(dir_rows[i].cmd);
            s = step_lamp_model(dir_rows[i].cmd);
            lamp_expect_q.push_back(dir_rows[i].typed ? dir_rows[i].want : s);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         release_req();
         write_csr(REG_TICK_RATE, CSR_DATA_W'(phase_rate[p]));
         write_csr(REG_LAMPS_READY, CSR_DATA_W'(phase_ready[p]));
         fast_mode = (p == 2) || (p == 6);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 4 && n == 40) hold_rsp = 1'b1;
            if (p == 5 && n == 120) begin
               release_req();
               wait_drained();
            end
            c = rand_cmd();
            send_word(c);
            lamp_expect_q.push_back(step_lamp_model(c));
         end
      end

      release_req();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && lamp_expect_q.size() == 0)
         $display("PASS led_blink_pattern_engine");
      else
         $display("FAIL led_blink_pattern_engine");
      $finish;
   end

endmodule
